// ===== rtl/zolt_pkg.sv =====
// shared types, sizes and key helper for the z ordered layer table
// no dependencies; compiled first
package zolt_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int CNT_W      = $clog2(MAX_LAYERS + 1);
    localparam int KEY_W      = 32;
    localparam int HANDLE_W   = 16;
    localparam int Z_W        = 16;
    localparam int TIE_W      = 16;
    localparam int POS_W      = 4;
    localparam int ENTRY_W    = 5;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_REORDER = 2'd2,
        ACT_READ    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic signed [Z_W-1:0] z;
        logic [TIE_W-1:0]      tie;
    } slot_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
        slot_t            ins;
        logic [CNT_W-1:0] cut;
        logic [CNT_W-1:0] count;
    } cell_cmd_t;

    // row summary back to the controller
    typedef struct packed {
        logic                found;
        logic [CNT_W-1:0]    idx;
        logic [TIE_W-1:0]    tie;
        logic                rd_hit;
        logic [HANDLE_W-1:0] rd_handle;
    } row_stat_t;

    // unsigned key whose order matches signed z then unsigned tie
    function automatic logic [KEY_W-1:0] make_key(input logic [Z_W-1:0] z,
                                                  input logic [TIE_W-1:0] tie);
        make_key = {~z[Z_W-1], z[Z_W-2:0], tie};
    endfunction

endpackage

// ===== rtl/zolt_if.sv =====
// valid/ready channel interfaces for the layer table input and result words
// no dependencies
interface zolt_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [15:0]       handle;
    logic signed [15:0] z_order;
    logic [15:0]       tie_id;
    logic [3:0]        position;

    modport source (output valid, action, handle, z_order, tie_id, position,
                    input ready);
    modport sink   (input valid, action, handle, z_order, tie_id, position,
                    output ready);
endinterface

interface zolt_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] entry_handle;
    logic [4:0]  entry_count;

    modport source (output valid, ok, entry_handle, entry_count, input ready);
    modport sink   (input valid, ok, entry_handle, entry_count, output ready);
endinterface

// ===== rtl/z_ordered_layer_table_top.sv =====
// flow: an accepted word is captured, goes through the execute step of the cell row (a reorder that
// finds its handle adds an insert step), then its result is pushed to the output register once that is free;
// one word at a time, a new word is taken in the same cycle the previous result is pushed
// reset: rst_n is asynchronous active low; clears the layer count, fsm and result valid,
// slot contents stay unknown until written and are never read before that
// depends on zolt_pkg, zolt_if, zolt_row, zolt_cell
module z_ordered_layer_table_top (
    input  logic       clk,
    input  logic       rst_n,
    zolt_in_if.sink    in_item,
    zolt_out_if.source result
);
    import zolt_pkg::*;

    // fsm
    state_t state_reg;
    state_t state_next;

    // captured input word
    act_t                  act_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [TIE_W-1:0]      tie_reg;
    logic [POS_W-1:0]      pos_reg;

    // table bookkeeping
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cut_reg;
    logic [TIE_W-1:0] keep_tie_reg;

    // pending result
    logic                res_ok_reg;
    logic [HANDLE_W-1:0] res_handle_reg;

    // output register
    logic                out_valid_reg;
    logic                out_ok_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [ENTRY_W-1:0]  out_count_reg;

    logic      in_take;
    logic      out_free;
    logic      out_load;
    logic      in_ready;
    logic      insert_phase;
    cell_op_t  op;
    cell_cmd_t cmd;
    row_stat_t stat;
    logic      full;

    assign full     = count_reg >= CNT_W'(MAX_LAYERS);
    assign out_free = !out_valid_reg || result.ready;
    assign in_take  = in_item.valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_take)
                    state_next = ST_EXEC;
            ST_EXEC:
                if ((act_reg == ACT_REORDER) && stat.found)
                    state_next = ST_INSERT;
                else
                    state_next = ST_DONE;
            ST_INSERT:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = in_take ? ST_EXEC : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        insert_phase = 1'b0;
        op           = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_EXEC:
            begin
                unique case (act_reg)
                    ACT_ADD:
                        if (!full)
                            op = CELL_INSERT;
                    ACT_REMOVE, ACT_REORDER:
                        op = CELL_REMOVE;
                    default:
                        op = CELL_HOLD;
                endcase
            end
            ST_INSERT:
            begin
                insert_phase = 1'b1;
                op           = CELL_INSERT;
            end
            ST_DONE:
            begin
                in_ready = out_free;
                out_load = out_free;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    // command broadcast to the cells; a plain add uses a cut above every slot
    // so equal keys all stay below, a reorder cuts at the slot it came from
    always_comb
    begin
        cmd            = '0;
        cmd.op         = op;
        cmd.count      = count_reg;
        cmd.ins.handle = handle_reg;
        cmd.ins.z      = z_reg;
        cmd.ins.tie    = insert_phase ? keep_tie_reg : tie_reg;
        cmd.key        = make_key(z_reg, cmd.ins.tie);
        cmd.cut        = insert_phase ? cut_reg : CNT_W'(MAX_LAYERS);
    end

    zolt_row u_row (
        .clk    (clk),
        .cmd    (cmd),
        .rd_pos (pos_reg),
        .stat   (stat)
    );

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (state_reg == ST_EXEC)
        begin
            if ((act_reg == ACT_ADD) && !full)
                count_next = count_reg + 1'b1;
            else if (((act_reg == ACT_REMOVE) || (act_reg == ACT_REORDER)) && stat.found)
                count_next = count_reg - 1'b1;
        end
        else if (state_reg == ST_INSERT)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg    <= act_t'(in_item.action);
            handle_reg <= in_item.handle;
            z_reg      <= in_item.z_order;
            tie_reg    <= in_item.tie_id;
            pos_reg    <= in_item.position;
        end

        if (state_reg == ST_EXEC)
        begin
            res_handle_reg <= '0;
            case (act_reg)
                ACT_ADD:
                    res_ok_reg <= !full;
                ACT_READ:
                begin
                    res_ok_reg     <= stat.rd_hit;
                    res_handle_reg <= stat.rd_handle;
                end
                default:
                    res_ok_reg <= stat.found;
            endcase
            // remember where the reordered entry stood and its tie
            cut_reg      <= stat.idx;
            keep_tie_reg <= stat.tie;
        end

        if (out_load)
        begin
            out_ok_reg     <= res_ok_reg;
            out_handle_reg <= res_handle_reg;
            out_count_reg  <= ENTRY_W'(count_reg);
        end
    end

    assign in_item.ready       = in_ready;
    assign result.valid        = out_valid_reg;
    assign result.ok           = out_ok_reg;
    assign result.entry_handle = out_handle_reg;
    assign result.entry_count  = out_count_reg;

endmodule

// ===== rtl/zolt_cell.sv =====
// one table slot: compares its key with the broadcast key and shifts with neighbors
// depends on zolt_pkg
module zolt_cell (
    input  logic               clk,
    input  logic [zolt_pkg::CNT_W-1:0] idx,
    input  zolt_pkg::cell_cmd_t cmd,
    input  zolt_pkg::slot_t    left_slot,
    input  logic               left_le,
    input  zolt_pkg::slot_t    right_slot,
    input  logic               found_in,
    output zolt_pkg::slot_t    slot,
    output logic               occ,
    output logic               le,
    output logic               found_out,
    output logic               first
);
    import zolt_pkg::*;

    slot_t            slot_reg;
    slot_t            slot_next;
    logic [KEY_W-1:0] own_key;
    logic             match;

    assign own_key   = make_key(slot_reg.z, slot_reg.tie);
    assign occ       = idx < cmd.count;
    // entries that stay below the insertion point
    assign le        = occ && ((own_key < cmd.key) ||
                               ((own_key == cmd.key) && (idx < cmd.cut)));
    assign match     = occ && (slot_reg.handle == cmd.ins.handle);
    assign found_out = found_in | match;
    assign first     = match & ~found_in;
    assign slot      = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!le)
                begin
                    if ((idx == '0) || left_le)
                        slot_next = cmd.ins;
                    else
                        slot_next = left_slot;
                end
            end
            CELL_REMOVE:
            begin
                if (found_out)
                    slot_next = right_slot;
            end
            default: slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== rtl/zolt_row.sv =====
// chain of slot cells plus the match and read summaries
// depends on zolt_pkg, zolt_cell
module zolt_row (
    input  logic                 clk,
    input  zolt_pkg::cell_cmd_t  cmd,
    input  logic [zolt_pkg::POS_W-1:0] rd_pos,
    output zolt_pkg::row_stat_t  stat
);
    import zolt_pkg::*;

    slot_t [MAX_LAYERS-1:0] slots;
    logic  [MAX_LAYERS-1:0] occ;
    logic  [MAX_LAYERS-1:0] le;
    logic  [MAX_LAYERS-1:0] found;
    logic  [MAX_LAYERS-1:0] first;

    genvar g;
    generate
        for (g = 0; g < MAX_LAYERS; g++)
        begin : g_cell
            slot_t lslot;
            slot_t rslot;
            logic  lle;
            logic  fin;

            if (g == 0)
            begin : g_lo
                assign lslot = '0;
                assign lle   = 1'b0;
                assign fin   = 1'b0;
            end
            else
            begin : g_mid
                assign lslot = slots[g-1];
                assign lle   = le[g-1];
                assign fin   = found[g-1];
            end

            // top cell has nothing above; whatever it keeps is past the count
            if (g == MAX_LAYERS - 1)
            begin : g_hi
                assign rslot = slots[g];
            end
            else
            begin : g_nhi
                assign rslot = slots[g+1];
            end

            zolt_cell u_cell (
                .clk        (clk),
                .idx        (CNT_W'(g)),
                .cmd        (cmd),
                .left_slot  (lslot),
                .left_le    (lle),
                .right_slot (rslot),
                .found_in   (fin),
                .slot       (slots[g]),
                .occ        (occ[g]),
                .le         (le[g]),
                .found_out  (found[g]),
                .first      (first[g])
            );
        end
    endgenerate

    // and-or selects over one-hot picks
    always_comb
    begin
        stat       = '0;
        stat.found = found[MAX_LAYERS-1];
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            if (first[i])
            begin
                stat.idx = stat.idx | CNT_W'(i);
                stat.tie = stat.tie | slots[i].tie;
            end
            if ((32'(rd_pos) == 32'(i)) && occ[i])
            begin
                stat.rd_hit    = 1'b1;
                stat.rd_handle = stat.rd_handle | slots[i].handle;
            end
        end
    end

endmodule

// ===== verif/tb_z_ordered_layer_table_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the z ordered layer table: a directed table, then random churn
// every result word is checked against a hand-typed result or an in-bench model of the sorted layer row
// depends on zolt_pkg, zolt_if and z_ordered_layer_table_top
module tb_z_ordered_layer_table_top;
    import zolt_pkg::*;

    localparam int HOLD_CYCLES = 80;     // long receiver hold-off, fills the block up
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 100;
    localparam int SETTLE      = 10;     // cycles after the last result word
    localparam int RUN_LIMIT   = 3_000_000;

    // one input word as the bench sees it
    typedef struct packed {
        act_t                  action;
        logic [HANDLE_W-1:0]   handle;
        logic signed [Z_W-1:0] z_order;
        logic [TIE_W-1:0]      tie_id;
        logic [POS_W-1:0]      position;
    } layer_word_t;

    // one result word
    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] entry_handle;
        logic [ENTRY_W-1:0]  entry_count;
    } layer_result_t;

    // directed row: typed marks a result written in by hand
    typedef struct {
        layer_word_t   word;
        bit            typed;
        layer_result_t want;
    } table_row_t;

    // action mix of a random phase
    typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

    // receiver behavior between long holds
    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_STARVE} rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    zolt_in_if  in_ch ();
    zolt_out_if out_ch ();

    z_ordered_layer_table_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch),
        .result  (out_ch)
    );

    // shadow copy of the layer row
    logic [HANDLE_W-1:0]   row_handle [MAX_LAYERS];
    logic signed [Z_W-1:0] row_z      [MAX_LAYERS];
    logic [TIE_W-1:0]      row_tie    [MAX_LAYERS];
    int                    row_count;

    layer_result_t pending_q [$];   // results still owed by the block, oldest first
    table_row_t    directed_q [$];
    int            errors        = 0;
    int            burst_left    = 0;
    int            hold_requests = 0;

    // receiver private state, only touched by the receiver process
    int            hold_served = 0;
    int            hold_left   = 0;
    int            rx_left     = 0;
    rx_mode_t      rx_mode     = RX_OPEN;
    logic [15:0]   rx_pat      = 16'hffff;

    // ------------------------------------------------------------------
    // layer row model
    // ------------------------------------------------------------------

    // flipping the z sign bit makes signed z then unsigned tie compare as one unsigned word
    function automatic logic [KEY_W-1:0] stack_key(logic [Z_W-1:0] z, logic [TIE_W-1:0] tie);
        return {z ^ 16'h8000, tie};
    endfunction

    // lowest slot holding the handle, row_count when absent
    function automatic int find_layer(logic [HANDLE_W-1:0] h);
        for (int i = 0; i < row_count; i++)
            if (row_handle[i] == h)
                return i;
        return row_count;
    endfunction

    function automatic void open_slot(int p, logic [HANDLE_W-1:0] h,
                                      logic signed [Z_W-1:0] z, logic [TIE_W-1:0] tie);
        for (int j = row_count; j > p; j--)
        begin
            row_handle[j] = row_handle[j-1];
            row_z[j]      = row_z[j-1];
            row_tie[j]    = row_tie[j-1];
        end
        row_handle[p] = h;
        row_z[p]      = z;
        row_tie[p]    = tie;
        row_count++;
    endfunction

    function automatic void close_slot(int p);
        for (int j = p + 1; j < row_count; j++)
        begin
            row_handle[j-1] = row_handle[j];
            row_z[j-1]      = row_z[j];
            row_tie[j-1]    = row_tie[j];
        end
        row_count--;
    endfunction

    // applies one word to the shadow row and returns the result word it owes
    function automatic layer_result_t apply_layer_action(layer_word_t w);
        layer_result_t    r;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] kj;
        logic [TIE_W-1:0] kept_tie;
        int               idx;
        int               p;
        r = '0;
        case (w.action)
            ACT_ADD:
            begin
                if (row_count < MAX_LAYERS)
                begin
                    // goes above every entry with a lower or equal key
                    k = stack_key(w.z_order, w.tie_id);
                    p = 0;
                    for (int j = 0; j < row_count; j++)
                        if (stack_key(row_z[j], row_tie[j]) <= k)
                            p = j + 1;
                    open_slot(p, w.handle, w.z_order, w.tie_id);
                    r.ok = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                idx = find_layer(w.handle);
                if (idx < row_count)
                begin
                    close_slot(idx);
                    r.ok = 1'b1;
                end
            end
            ACT_REORDER:
            begin
                idx = find_layer(w.handle);
                if (idx < row_count)
                begin
                    // keeps its tie, equal keys that stood below it stay below
                    kept_tie = row_tie[idx];
                    k = stack_key(w.z_order, kept_tie);
                    close_slot(idx);
                    p = 0;
                    for (int j = 0; j < row_count; j++)
                    begin
                        kj = stack_key(row_z[j], row_tie[j]);
                        if (kj < k || (kj == k && j < idx))
                            p++;
                    end
                    open_slot(p, w.handle, w.z_order, kept_tie);
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                if (int'(w.position) < row_count)
                begin
                    r.entry_handle = row_handle[w.position];
                    r.ok = 1'b1;
                end
            end
        endcase
        r.entry_count = ENTRY_W'(row_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic add_row(input act_t a, input int h, input int z, input int tie,
                           input int pos, input bit typed, input bit ok, input int eh,
                           input int cnt);
        table_row_t row;
        row.word.action       = a;
        row.word.handle       = HANDLE_W'(h);
        row.word.z_order      = Z_W'(z);
        row.word.tie_id       = TIE_W'(tie);
        row.word.position     = POS_W'(pos);
        row.typed             = typed;
        row.want.ok           = ok;
        row.want.entry_handle = HANDLE_W'(eh);
        row.want.entry_count  = ENTRY_W'(cnt);
        directed_q.push_back(row);
    endtask

    // random word, mostly aimed at handles that are really in the row
    function automatic layer_word_t gen_random_word(mix_t mix);
        layer_word_t w;
        int          roll;
        int          add_pct;
        int          rem_pct;
        int          ord_pct;
        w.handle   = HANDLE_W'($urandom);
        w.z_order  = Z_W'($urandom);
        w.tie_id   = TIE_W'($urandom);
        w.position = POS_W'($urandom);
        w.action   = act_t'($urandom_range(0, 3));
        // plain noise now and then
        if ($urandom_range(0, 99) < 5)
            return w;
        case (mix)
            MIX_FILL:
            begin
                add_pct = 55; rem_pct = 15; ord_pct = 15;
            end
            MIX_DRAIN:
            begin
                add_pct = 15; rem_pct = 50; ord_pct = 15;
            end
            default:
            begin
                add_pct = 25; rem_pct = 25; ord_pct = 25;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            w.action = ACT_ADD;
        else if (roll < add_pct + rem_pct)
            w.action = ACT_REMOVE;
        else if (roll < add_pct + rem_pct + ord_pct)
            w.action = ACT_REORDER;
        else
            w.action = ACT_READ;
        // handles: held ones, a small pool for duplicates, or anything
        roll = $urandom_range(0, 99);
        if (roll < 60 && row_count > 0)
            w.handle = row_handle[$urandom_range(0, row_count - 1)];
        else if (roll < 85)
            w.handle = HANDLE_W'($urandom_range(0, 7));
        // z: a narrow band so keys collide, the extremes, or anything
        roll = $urandom_range(0, 99);
        if (roll < 40)
            w.z_order = Z_W'($urandom_range(0, 4) - 2);
        else if (roll < 60)
        begin
            case ($urandom_range(0, 3))
                0:       w.z_order = 16'sh8000;
                1:       w.z_order = 16'sh7fff;
                2:       w.z_order = -16'sd1;
                default: w.z_order = 16'sd0;
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
            w.tie_id = TIE_W'($urandom_range(0, 3));
        else if (roll < 65)
            w.tie_id = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        if ($urandom_range(0, 1) == 1 && row_count > 0)
            w.position = POS_W'($urandom_range(0, row_count - 1));
        return w;
    endfunction

    // drives one word in bursts with random gaps, owes its result once accepted
    task automatic send_word(input layer_word_t w, input layer_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        else
            gap = 0;
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= w.action;
        in_ch.handle   <= w.handle;
        in_ch.z_order  <= w.z_order;
        in_ch.tie_id   <= w.tie_id;
        in_ch.position <= w.position;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_q.push_back(want);
    endtask

    // sender goes quiet until the block has answered everything
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        layer_result_t got;
        layer_word_t   w;
        in_ch.valid    = 1'b0;
        in_ch.action   = ACT_ADD;
        in_ch.handle   = '0;
        in_ch.z_order  = '0;
        in_ch.tie_id   = '0;
        in_ch.position = '0;
        row_count      = 0;
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            row_handle[i] = '0;
            row_z[i]      = '0;
            row_tie[i]    = '0;
        end

        // empty table: every lookup misses
        add_row(ACT_READ,    0,      0,      0,      0,  1, 0, 0,      0);
        add_row(ACT_REMOVE,  0,      0,      0,      0,  1, 0, 0,      0);
        add_row(ACT_REORDER, 'hffff, 0,      0,      0,  1, 0, 0,      0);
        // extreme keys and handles at both ends of the row
        add_row(ACT_ADD,     'hffff, 32767,  'hffff, 15, 1, 1, 0,      1);
        add_row(ACT_ADD,     0,      -32768, 0,      0,  1, 1, 0,      2);
        add_row(ACT_READ,    0,      0,      0,      0,  1, 1, 0,      2);
        add_row(ACT_READ,    0,      0,      0,      1,  1, 1, 'hffff, 2);
        // read beyond the count
        add_row(ACT_READ,    0,      0,      0,      15, 1, 0, 0,      2);
        // equal keys and a duplicate handle
        add_row(ACT_ADD,     5,      0,      7,      0,  1, 1, 0,      3);
        add_row(ACT_ADD,     6,      0,      7,      0,  1, 1, 0,      4);
        add_row(ACT_ADD,     5,      0,      7,      0,  1, 1, 0,      5);
        // remove takes the lowest copy, reorder keeps its tie
        add_row(ACT_REMOVE,  5,      0,      0,      0,  0, 0, 0,      0);
        add_row(ACT_REORDER, 6,      -32768, 'hffff, 0,  0, 0, 0,      0);
        // fill up with colliding keys
        for (int i = 0; i < MAX_LAYERS - 4; i++)
            add_row(ACT_ADD, 'h100 + i, (i % 3) - 1, i % 2, 0, 0, 0, 0, 0);
        // full table refuses the add
        add_row(ACT_ADD,     'h1234, 0,      0,      0,  1, 0, 0,      MAX_LAYERS);
        add_row(ACT_READ,    0,      0,      0,      15, 0, 0, 0,      0);
        add_row(ACT_REORDER, 'h0101, 1,      0,      0,  0, 0, 0,      0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i])
        begin
            got = apply_layer_action(directed_q[i].word);
            send_word(directed_q[i].word, directed_q[i].typed ? directed_q[i].want : got);
        end
        drain_results();

        // random phases rotate the mix so the row fills, churns and empties
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                w   = gen_random_word(mix_t'(ph % 3));
                got = apply_layer_action(w);
                send_word(w, got);
                // long receiver hold while the sender keeps offering
                if (n == 10 && (ph == 1 || ph == 7))
                    hold_requests++;
            end
            drain_results();
        end

        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stalls on its own pattern, with occasional long holds
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 80);
                rx_pat  = 16'($urandom);
            end
            else
                rx_left--;
            rx_pat = {rx_pat[14:0], rx_pat[15]};
            case (rx_mode)
                RX_OPEN:    out_ch.ready <= 1'b1;
                RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_ch.ready <= rx_pat[0];
                default:    out_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker: each accepted word against the oldest owed result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        layer_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result word ok=%0d handle=%h count=%0d", $time,
                         out_ch.ok, out_ch.entry_handle, out_ch.entry_count);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (out_ch.ok !== want.ok)
                begin
                    $display("%0t: ok mismatch expected %0d actual %0d", $time,
                             want.ok, out_ch.ok);
                    errors++;
                end
                if (out_ch.entry_handle !== want.entry_handle)
                begin
                    $display("%0t: entry_handle mismatch expected %h actual %h", $time,
                             want.entry_handle, out_ch.entry_handle);
                    errors++;
                end
                if (out_ch.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count mismatch expected %0d actual %0d", $time,
                             want.entry_count, out_ch.entry_count);
                    errors++;
                end
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule
